@@ rtl/gwff_pkg.sv @@
// ----------------------------------------------------------------------------
// gwff_pkg
// Shared types and constants of the grid wavefront flow field unit: cell word
// layout, operation and register codes, step costs and neighbour offsets.
// ----------------------------------------------------------------------------
package gwff_pkg;

   localparam int COST_W = 24;

   localparam logic [COST_W-1:0] COST_UNREACH = 24'hFFFFFF;
   localparam logic [COST_W-1:0] COST_MAXF    = 24'hFFFFFE;
   localparam logic [8:0]        STEP_STRAIGHT = 9'd256;
   localparam logic [8:0]        STEP_DIAG     = 9'd362;

   // request operations
   localparam logic [1:0] OP_CLEAR     = 2'd0;
   localparam logic [1:0] OP_MARK      = 2'd1;
   localparam logic [1:0] OP_INTEGRATE = 2'd2;
   localparam logic [1:0] OP_READ      = 2'd3;

   // register indexes
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   localparam logic [3:0] DIR_NONE = 4'd8;

   // one cell of the grid memory
   typedef struct packed {
      logic              obstacle;
      logic              queued;
      logic [COST_W-1:0] cost;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   // neighbour offsets in direction-code order
   function automatic logic signed [1:0] nb_drow(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd0, 3'd4, 3'd5: d = -2'sd1;
         3'd2, 3'd6, 3'd7: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] nb_dcol(input logic [2:0] k);
      logic signed [1:0] d;
      case (k)
         3'd1, 3'd4, 3'd6: d = -2'sd1;
         3'd3, 3'd5, 3'd7: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

@@ rtl/grid_wavefront_flow_field_unit.sv @@
// ----------------------------------------------------------------------------
// grid_wavefront_flow_field_unit
// Obstacle grid and cost field with an 8-neighbour FIFO wavefront flood.
// One request at a time; the cell memory port sets the pace (one access/cycle).
// Reset: a clearing pass frees all cells and sets all costs unreachable; no
//   request is taken until it ends.
// ----------------------------------------------------------------------------
module grid_wavefront_flow_field_unit #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [5:0]  req_first_row,
   input  logic [5:0]  req_first_col,
   input  logic [5:0]  req_last_row,
   input  logic [5:0]  req_last_col,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [23:0] rsp_path_cost,
   output logic        rsp_reachable,
   output logic [3:0]  rsp_direction,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   import gwff_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;

   // sequencer states
   typedef enum logic [10:0] {
      ST_INIT    = 11'b000_0000_0001,
      ST_IDLE    = 11'b000_0000_0010,
      ST_SWEEP   = 11'b000_0000_0100,
      ST_RECT    = 11'b000_0000_1000,
      ST_PT_RD   = 11'b000_0001_0000,
      ST_PT_DATA = 11'b000_0010_0000,
      ST_DEQ     = 11'b000_0100_0000,
      ST_CUR_A   = 11'b000_1000_0000,
      ST_CUR_B   = 11'b001_0000_0000,
      ST_NB      = 11'b010_0000_0000,
      ST_RESP    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0] grid_rows_ff, grid_rows_in;
   logic [6:0] grid_cols_ff, grid_cols_in;

   logic [1:0]        op_ff, op_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [CW-1:0]     fc_ff, fc_in;
   logic [RW-1:0]     lr_ff, lr_in;
   logic [CW-1:0]     lc_ff, lc_in;
   logic              rect_more_ff, rect_more_in;
   logic [AW:0]       swp_cnt_ff, swp_cnt_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [2:0]        pend_dir_ff, pend_dir_in;
   logic [3:0]        k_ff, k_in;
   logic [COST_W-1:0] cur_cost_ff, cur_cost_in;
   logic              cur_obst_ff, cur_obst_in;
   logic [COST_W-1:0] best_ff, best_in;
   logic [3:0]        dir_ff, dir_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [AW:0]       count_ff, count_in;

   logic              res_status_ff, res_status_in;
   logic [COST_W-1:0] res_cost_ff, res_cost_in;
   logic              res_reach_ff, res_reach_in;
   logic [3:0]        res_dir_ff, res_dir_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic              rsp_reach_ff, rsp_reach_in;
   logic [3:0]        rsp_dir_ff, rsp_dir_in;

   // memory ports
   logic              c_we;
   logic [AW-1:0]     c_waddr, c_raddr;
   cell_type          c_wdata, c_rdata;
   logic [CELL_W-1:0] c_rdata_raw;
   logic              q_we;
   logic [AW-1:0]     q_wdata, q_rdata;

   // grid in use: zero acts as one, above the maximum acts as the maximum
   logic [8:0] rows_lim, cols_lim;

   always_comb begin
      if (grid_rows_ff == 7'd0) begin
         rows_lim = 9'd1;
      end else if (9'(grid_rows_ff) > 9'(MAX_ROWS)) begin
         rows_lim = 9'(MAX_ROWS);
      end else begin
         rows_lim = 9'(grid_rows_ff);
      end
      if (grid_cols_ff == 7'd0) begin
         cols_lim = 9'd1;
      end else if (9'(grid_cols_ff) > 9'(MAX_COLS)) begin
         cols_lim = 9'(MAX_COLS);
      end else begin
         cols_lim = 9'(grid_cols_ff);
      end
   end

   // request decode
   logic       pt_out;
   logic [8:0] lr_clip, lc_clip;
   logic       rect_empty;

   assign pt_out     = (9'(req_first_row) >= rows_lim) || (9'(req_first_col) >= cols_lim);
   assign lr_clip    = (9'(req_last_row) >= rows_lim) ? rows_lim - 9'd1 : 9'(req_last_row);
   assign lc_clip    = (9'(req_last_col) >= cols_lim) ? cols_lim - 9'd1 : 9'(req_last_col);
   assign rect_empty = (9'(req_first_row) > lr_clip) || (9'(req_first_col) > lc_clip);

   // neighbour k of the current cell
   logic signed [RW+1:0] nb_r;
   logic signed [CW+1:0] nb_c;
   logic                 nb_in_grid;
   logic [AW-1:0]        nb_addr;

   assign nb_r = $signed({2'b00, cur_row_ff}) + (RW+2)'(nb_drow(k_ff[2:0]));
   assign nb_c = $signed({2'b00, cur_col_ff}) + (CW+2)'(nb_dcol(k_ff[2:0]));
   assign nb_in_grid = !nb_r[RW+1] && !nb_c[CW+1]
                       && (9'(nb_r[RW:0]) < rows_lim) && (9'(nb_c[CW:0]) < cols_lim);
   assign nb_addr = {nb_r[RW-1:0], nb_c[CW-1:0]};

   // relaxation of the pending neighbour, saturating below unreachable
   logic [COST_W:0]   step_sum;
   logic [COST_W-1:0] new_cost;

   assign step_sum = (COST_W+1)'(cur_cost_ff)
                     + (COST_W+1)'(pend_dir_ff[2] ? STEP_DIAG : STEP_STRAIGHT);
   assign new_cost = (step_sum > (COST_W+1)'(COST_MAXF)) ? COST_MAXF : step_sum[COST_W-1:0];

   assign c_rdata   = cell_type'(c_rdata_raw);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      grid_rows_in  = grid_rows_ff;
      grid_cols_in  = grid_cols_ff;
      op_in         = op_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      fc_in         = fc_ff;
      lr_in         = lr_ff;
      lc_in         = lc_ff;
      rect_more_in  = rect_more_ff;
      swp_cnt_in    = swp_cnt_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_dir_in   = pend_dir_ff;
      k_in          = k_ff;
      cur_cost_in   = cur_cost_ff;
      cur_obst_in   = cur_obst_ff;
      best_in       = best_ff;
      dir_in        = dir_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_cost_in   = res_cost_ff;
      res_reach_in  = res_reach_ff;
      res_dir_in    = res_dir_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cost_in   = rsp_cost_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_dir_in    = rsp_dir_ff;
      c_we          = 1'b0;
      c_waddr       = pend_addr_ff;
      c_wdata       = c_rdata;
      c_raddr       = {cur_row_ff, cur_col_ff};
      q_we          = 1'b0;
      q_wdata       = {cur_row_ff, cur_col_ff};

      // register writes land at once; the block is idle by contract
      if (csr_valid) begin
         case (csr_index)
            CSR_ROWS: grid_rows_in = csr_data;
            CSR_COLS: grid_cols_in = csr_data;
            default:  grid_rows_in = grid_rows_ff;
         endcase
      end

      // drop the response once it transfers
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT, ST_SWEEP: begin
            // read-modify-write every entry, read one ahead of the write
            c_raddr = swp_cnt_ff[AW-1:0];
            if (!swp_cnt_ff[AW]) begin
               pend_valid_in = 1'b1;
               pend_addr_in  = swp_cnt_ff[AW-1:0];
               swp_cnt_in    = swp_cnt_ff + 1'b1;
            end
            if (pend_valid_ff) begin
               c_we = 1'b1;
               if (state_ff == ST_INIT) begin
                  c_wdata = '{obstacle: 1'b0, queued: 1'b0, cost: COST_UNREACH};
               end else if (op_ff == OP_CLEAR) begin
                  c_wdata.obstacle = 1'b0;
               end else begin
                  c_wdata.cost = COST_UNREACH;
               end
            end
            if (swp_cnt_ff[AW] && !pend_valid_ff) begin
               if (state_ff == ST_INIT) begin
                  state_in = ST_IDLE;
               end else if (op_ff == OP_CLEAR || res_status_ff) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_PT_RD;
               end
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_operation;
               res_status_in = 1'b0;
               res_cost_in   = '0;
               res_reach_in  = 1'b0;
               res_dir_in    = DIR_NONE;
               cur_row_in    = RW'(req_first_row);
               cur_col_in    = CW'(req_first_col);
               swp_cnt_in    = '0;
               case (req_operation)
                  OP_CLEAR: begin
                     state_in = ST_SWEEP;
                  end
                  OP_MARK: begin
                     fc_in        = CW'(req_first_col);
                     lr_in        = RW'(lr_clip);
                     lc_in        = CW'(lc_clip);
                     rect_more_in = 1'b1;
                     state_in     = rect_empty ? ST_RESP : ST_RECT;
                  end
                  OP_INTEGRATE: begin
                     res_status_in = pt_out;
                     head_in       = '0;
                     tail_in       = '0;
                     count_in      = '0;
                     state_in      = ST_SWEEP;
                  end
                  OP_READ: begin
                     if (pt_out) begin
                        res_status_in = 1'b1;
                        res_cost_in   = COST_UNREACH;
                        state_in      = ST_RESP;
                     end else begin
                        state_in = ST_PT_RD;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_RECT: begin
            // walk the clipped rectangle row by row, setting the obstacle bit
            if (rect_more_ff) begin
               pend_valid_in = 1'b1;
               pend_addr_in  = {cur_row_ff, cur_col_ff};
               if (cur_col_ff == lc_ff) begin
                  cur_col_in = fc_ff;
                  if (cur_row_ff == lr_ff) begin
                     rect_more_in = 1'b0;
                  end else begin
                     cur_row_in = cur_row_ff + 1'b1;
                  end
               end else begin
                  cur_col_in = cur_col_ff + 1'b1;
               end
            end
            if (pend_valid_ff) begin
               c_we             = 1'b1;
               c_wdata.obstacle = 1'b1;
            end
            if (!rect_more_ff && !pend_valid_ff) begin
               state_in = ST_RESP;
            end
         end

         ST_PT_RD: begin
            state_in = ST_PT_DATA;
         end

         ST_PT_DATA: begin
            if (op_ff == OP_READ) begin
               cur_cost_in = c_rdata.cost;
               cur_obst_in = c_rdata.obstacle;
               best_in     = COST_UNREACH;
               dir_in      = DIR_NONE;
               k_in        = '0;
               state_in    = ST_NB;
            end else begin
               // seed the goal at cost zero, even on an obstacle
               c_we           = 1'b1;
               c_waddr        = {cur_row_ff, cur_col_ff};
               c_wdata.queued = 1'b1;
               c_wdata.cost   = '0;
               q_we           = 1'b1;
               tail_in        = tail_ff + 1'b1;
               count_in       = count_ff + 1'b1;
               state_in       = ST_DEQ;
            end
         end

         ST_DEQ: begin
            if (count_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               head_in  = head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               state_in = ST_CUR_A;
            end
         end

         ST_CUR_A: begin
            c_raddr    = q_rdata;
            cur_row_in = q_rdata[AW-1:CW];
            cur_col_in = q_rdata[CW-1:0];
            state_in   = ST_CUR_B;
         end

         ST_CUR_B: begin
            // hold the cell's cost and release its queued mark
            cur_cost_in    = c_rdata.cost;
            c_we           = 1'b1;
            c_waddr        = {cur_row_ff, cur_col_ff};
            c_wdata.queued = 1'b0;
            k_in           = '0;
            state_in       = ST_NB;
         end

         ST_NB: begin
            // read neighbour k while the one before it is evaluated
            c_raddr = nb_addr;
            if (!k_ff[3]) begin
               pend_valid_in = nb_in_grid;
               pend_addr_in  = nb_addr;
               pend_dir_in   = k_ff[2:0];
               k_in          = k_ff + 1'b1;
            end
            if (pend_valid_ff) begin
               if (op_ff == OP_READ) begin
                  if (c_rdata.cost < best_ff) begin
                     best_in = c_rdata.cost;
                     dir_in  = {1'b0, pend_dir_ff};
                  end
               end else if (new_cost < c_rdata.cost && !c_rdata.obstacle) begin
                  c_we           = 1'b1;
                  c_wdata.cost   = new_cost;
                  c_wdata.queued = 1'b1;
                  if (!c_rdata.queued) begin
                     q_we     = 1'b1;
                     q_wdata  = pend_addr_ff;
                     tail_in  = tail_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            if (k_ff[3]) begin
               if (op_ff == OP_READ) begin
                  res_cost_in  = cur_cost_ff;
                  res_reach_in = (cur_cost_ff != COST_UNREACH);
                  res_dir_in   = cur_obst_ff ? DIR_NONE : dir_in;
                  state_in     = ST_RESP;
               end else begin
                  state_in = ST_DEQ;
               end
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cost_in   = res_cost_ff;
               rsp_reach_in  = res_reach_ff;
               rsp_dir_in    = res_dir_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         grid_rows_ff  <= 7'd64;
         grid_cols_ff  <= 7'd64;
         rect_more_ff  <= 1'b0;
         swp_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         k_ff          <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         grid_rows_ff  <= grid_rows_in;
         grid_cols_ff  <= grid_cols_in;
         rect_more_ff  <= rect_more_in;
         swp_cnt_ff    <= swp_cnt_in;
         pend_valid_ff <= pend_valid_in;
         k_ff          <= k_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      fc_ff         <= fc_in;
      lr_ff         <= lr_in;
      lc_ff         <= lc_in;
      pend_addr_ff  <= pend_addr_in;
      pend_dir_ff   <= pend_dir_in;
      cur_cost_ff   <= cur_cost_in;
      cur_obst_ff   <= cur_obst_in;
      best_ff       <= best_in;
      dir_ff        <= dir_in;
      res_status_ff <= res_status_in;
      res_cost_ff   <= res_cost_in;
      res_reach_ff  <= res_reach_in;
      res_dir_ff    <= res_dir_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_dir_ff    <= rsp_dir_in;
   end

   // obstacle bit, queued mark and cost of every cell
   gwff_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (c_raddr),
      .rd_data (c_rdata_raw)
   );

   // wavefront FIFO of cell addresses
   gwff_ram #(
      .WIDTH (AW),
      .DEPTH (DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff),
      .wr_data (q_wdata),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_path_cost = rsp_cost_ff;
   assign rsp_reachable = rsp_reach_ff;
   assign rsp_direction = rsp_dir_ff;

endmodule

@@ rtl/gwff_ram.sv @@
// ----------------------------------------------------------------------------
// gwff_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gwff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
